// ----- rtl/core/whm_pkg.sv -----
// Shared types, sizes and the weight table for the window hash matcher.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package whm_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int MAX_LENGTH = 1048576;

  localparam longint unsigned HASH_PRIME = 64'd1000000007;
  localparam longint unsigned HASH_BASE  = 64'd1009;

  localparam int SYM_W   = 8;
  localparam int HASH_W  = 30;
  localparam int KLEN_W  = 7;
  localparam int START_W = 20;

  localparam int WIN_IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int KEFF_W    = $clog2(MAX_WINDOW + 1);
  localparam int POS_W     = $clog2(MAX_LENGTH + 1);

  localparam int TREE_LEVELS = $clog2(MAX_WINDOW);
  localparam int TREE_LEAVES = 1 << TREE_LEVELS;
  localparam int PROD_W      = HASH_W + SYM_W;
  localparam int SUM_W       = PROD_W + TREE_LEVELS;
  localparam int RED_STEPS   = SUM_W - HASH_W + 1;

  // product, tree, reduction, queue write, queue head
  localparam int LATENCY     = TREE_LEVELS + RED_STEPS + 4;
  localparam int QUEUE_AW    = $clog2(LATENCY + 1);
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
  localparam int CREDIT_W    = QUEUE_AW + 1;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } sym_req_t;

  typedef struct packed {
    logic               match;
    logic [START_W-1:0] start_index;
    logic               not_found;
  } res_req_t;

  typedef struct packed {
    logic               valid;
    logic               elig;
    logic               last;
    logic [START_W-1:0] start;
  } meta_t;

  typedef logic [HASH_W-1:0] weight_arr_t [MAX_WINDOW];

  function automatic weight_arr_t weight_init();
    weight_arr_t     w;
    longint unsigned acc;
    acc = 64'd1;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      w[i] = acc[HASH_W-1:0];
      acc  = (acc * HASH_BASE) % HASH_PRIME;
    end
    return w;
  endfunction

  localparam weight_arr_t WEIGHT = weight_init();

endpackage

`default_nettype wire

// ----- rtl/core/whm_cell.sv -----
// One window cell: holds a symbol, hands it on when the window shifts,
// and registers its weighted product. Depends on whm_pkg.
`default_nettype none

module whm_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift,
  input  logic [whm_pkg::SYM_W-1:0]  sym_in,
  input  logic [whm_pkg::HASH_W-1:0] coef_in,
  output logic [whm_pkg::SYM_W-1:0]  sym_out,
  output logic [whm_pkg::PROD_W-1:0] prod
);

  logic [whm_pkg::SYM_W-1:0]  sym;
  logic [whm_pkg::HASH_W-1:0] coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      sym <= '0;
    end else if (shift) begin
      sym <= sym_in;
    end
  end

  always_ff @(posedge clk) begin
    coef <= coef_in;
    prod <= whm_pkg::PROD_W'(coef) * whm_pkg::PROD_W'(sym);
  end

  assign sym_out = sym;

endmodule

`default_nettype wire

// ----- rtl/core/whm_sum_tree.sv -----
// Registered binary adder tree over the cell products, with the request
// tag carried alongside. Depends on whm_pkg.
`default_nettype none

module whm_sum_tree (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [whm_pkg::PROD_W-1:0] leaf [whm_pkg::MAX_WINDOW],
  input  whm_pkg::meta_t             meta_in,
  output logic [whm_pkg::SUM_W-1:0]  sum,
  output whm_pkg::meta_t             meta_out
);

  localparam int L = whm_pkg::TREE_LEAVES;

  logic [whm_pkg::SUM_W-1:0] leaf_ext [L];
  logic [whm_pkg::SUM_W-1:0] node [1:L-1];
  whm_pkg::meta_t            meta_q [whm_pkg::TREE_LEVELS];

  for (genvar n = 0; n < L; n++) begin : g_leaf
    if (n < whm_pkg::MAX_WINDOW) begin : g_used
      assign leaf_ext[n] = whm_pkg::SUM_W'(leaf[n]);
    end else begin : g_pad
      assign leaf_ext[n] = '0;
    end
  end

  for (genvar n = 1; n < L; n++) begin : g_node
    if (2 * n >= L) begin : g_bottom
      always_ff @(posedge clk) begin
        node[n] <= leaf_ext[2*n-L] + leaf_ext[2*n+1-L];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node[n] <= node[2*n] + node[2*n+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < whm_pkg::TREE_LEVELS; s++) begin
        meta_q[s] <= '0;
      end
    end else begin
      meta_q[0] <= meta_in;
      for (int s = 1; s < whm_pkg::TREE_LEVELS; s++) begin
        meta_q[s] <= meta_q[s-1];
      end
    end
  end

  assign sum      = node[1];
  assign meta_out = meta_q[whm_pkg::TREE_LEVELS-1];

endmodule

`default_nettype wire

// ----- rtl/core/whm_mod_reduce.sv -----
// Pipelined reduction modulo the hash prime: one shifted compare and
// subtract per stage. Depends on whm_pkg.
`default_nettype none

module whm_mod_reduce (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [whm_pkg::SUM_W-1:0]  sum_in,
  input  whm_pkg::meta_t             meta_in,
  output logic [whm_pkg::HASH_W-1:0] hash,
  output whm_pkg::meta_t             meta_out
);

  logic [whm_pkg::SUM_W-1:0] val [whm_pkg::RED_STEPS];
  whm_pkg::meta_t            meta_q [whm_pkg::RED_STEPS];

  for (genvar s = 0; s < whm_pkg::RED_STEPS; s++) begin : g_step
    localparam logic [whm_pkg::SUM_W-1:0] MOD_SHIFTED =
      whm_pkg::SUM_W'(whm_pkg::HASH_PRIME << (whm_pkg::RED_STEPS - 1 - s));
    logic [whm_pkg::SUM_W-1:0] src;

    if (s == 0) begin : g_first
      assign src = sum_in;
    end else begin : g_rest
      assign src = val[s-1];
    end

    always_ff @(posedge clk) begin
      val[s] <= (src >= MOD_SHIFTED) ? src - MOD_SHIFTED : src;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < whm_pkg::RED_STEPS; s++) begin
        meta_q[s] <= '0;
      end
    end else begin
      meta_q[0] <= meta_in;
      for (int s = 1; s < whm_pkg::RED_STEPS; s++) begin
        meta_q[s] <= meta_q[s-1];
      end
    end
  end

  assign hash     = val[whm_pkg::RED_STEPS-1][whm_pkg::HASH_W-1:0];
  assign meta_out = meta_q[whm_pkg::RED_STEPS-1];

endmodule

`default_nettype wire

// ----- rtl/core/whm_result_queue.sv -----
// Result queue with a registered head; parts the result side from the
// pipeline. Depends on whm_pkg.
`default_nettype none

module whm_result_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  whm_pkg::res_req_t wr_data,
  input  logic              rd_en,
  output logic              head_valid,
  output whm_pkg::res_req_t head
);

  whm_pkg::res_req_t            mem [whm_pkg::QUEUE_DEPTH];
  logic [whm_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [whm_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [whm_pkg::QUEUE_AW:0]   count;
  logic [whm_pkg::QUEUE_AW:0]   count_next;
  logic                         pop;
  logic                         load;

  assign pop  = head_valid && rd_en;
  assign load = (count != '0) && (!head_valid || pop);

  always_comb begin
    count_next = count;
    if (wr_en) begin
      count_next = count_next + 1'b1;
    end
    if (load) begin
      count_next = count_next - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
    if (load) begin
      head <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
      head_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (load) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
      if (load) begin
        head_valid <= 1'b1;
      end else if (pop) begin
        head_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/window_hash_matcher_top.sv -----
// Top level of the window hash matcher: register port, cell row, adder
// tree, modular reduction, match tracking and result queue. Uses whm_pkg.
//
// channel  direction  handshake              payload / map
// sym      in         sym_valid, sym_stall   whm_pkg::sym_req_t
// res      out        res_valid, res_stall   whm_pkg::res_req_t
// apb      in         psel, penable, pready  0x0 window_length, 0x4 target_hash
//
// One symbol request is taken every cycle while sym_stall is low; each gives one result,
// which passes the product row, a six-level adder tree and fifteen reduction steps.
// A queue of 32 results absorbs res_stall; sym_stall rises only with 32 pending.
// rst is synchronous: it clears the window, position, match flag and queue,
// and sets window_length to 1 and target_hash to 0.
`default_nettype none

module window_hash_matcher_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              sym_valid,
  output logic              sym_stall,
  input  whm_pkg::sym_req_t sym_data,
  output logic              res_valid,
  input  logic              res_stall,
  output whm_pkg::res_req_t res_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_TARGET_HASH   = 1'b1;

  logic [whm_pkg::KLEN_W-1:0]   window_length;
  logic [whm_pkg::HASH_W-1:0]   target_hash;
  logic [whm_pkg::KEFF_W-1:0]   k_eff;

  logic                         accept;
  logic                         deliver;
  logic                         stored;
  logic [whm_pkg::POS_W-1:0]    pos;
  logic [whm_pkg::POS_W-1:0]    pos_inc;
  logic [whm_pkg::POS_W-1:0]    pos_next;
  logic [whm_pkg::CREDIT_W-1:0] credits;
  logic [whm_pkg::CREDIT_W-1:0] credits_next;

  logic [whm_pkg::SYM_W-1:0]    chain [whm_pkg::MAX_WINDOW];
  logic [whm_pkg::PROD_W-1:0]   prod [whm_pkg::MAX_WINDOW];

  whm_pkg::meta_t               meta_in;
  whm_pkg::meta_t               meta_prod;
  whm_pkg::meta_t               meta_mul;
  whm_pkg::meta_t               meta_tree;
  whm_pkg::meta_t               meta_red;
  logic [whm_pkg::SUM_W-1:0]    tree_sum;
  logic [whm_pkg::HASH_W-1:0]   red_hash;

  logic                         found;
  logic                         hit;
  whm_pkg::res_req_t            res_w;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= whm_pkg::KLEN_W'(1);
      target_hash   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_WINDOW_LENGTH: window_length <= pwdata[whm_pkg::KLEN_W-1:0];
        REG_TARGET_HASH:   target_hash   <= pwdata[whm_pkg::HASH_W-1:0];
        default:           window_length <= window_length;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_LENGTH: prdata = 32'(window_length);
      REG_TARGET_HASH:   prdata = 32'(target_hash);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    priority if (window_length == '0) begin
      k_eff = whm_pkg::KEFF_W'(1);
    end else if (int'(window_length) > whm_pkg::MAX_WINDOW) begin
      k_eff = whm_pkg::KEFF_W'(whm_pkg::MAX_WINDOW);
    end else begin
      k_eff = whm_pkg::KEFF_W'(window_length);
    end
  end

  // request intake and position tracking
  assign accept  = sym_valid && !sym_stall;
  assign deliver = res_valid && !res_stall;
  assign stored  = pos < whm_pkg::POS_W'(whm_pkg::MAX_LENGTH);
  assign pos_inc = pos + 1'b1;

  always_comb begin
    priority if (accept && sym_data.last) begin
      pos_next = '0;
    end else if (accept && stored) begin
      pos_next = pos_inc;
    end else begin
      pos_next = pos;
    end
  end

  always_comb begin
    meta_in.valid = accept;
    meta_in.elig  = stored && (pos_inc >= whm_pkg::POS_W'(k_eff));
    meta_in.last  = sym_data.last;
    meta_in.start = whm_pkg::START_W'(pos_inc - whm_pkg::POS_W'(k_eff));
  end

  always_comb begin
    unique case ({accept, deliver})
      2'b10:   credits_next = credits + 1'b1;
      2'b01:   credits_next = credits - 1'b1;
      default: credits_next = credits;
    endcase
  end

  assign sym_stall = (credits == whm_pkg::CREDIT_W'(whm_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      credits   <= '0;
      meta_prod <= '0;
      meta_mul  <= '0;
    end else begin
      pos       <= pos_next;
      credits   <= credits_next;
      meta_prod <= meta_in;
      meta_mul  <= meta_prod;
    end
  end

  // cell row: newest symbol in cell 0
  assign chain[0] = sym_data.symbol;

  for (genvar i = 0; i < whm_pkg::MAX_WINDOW; i++) begin : g_cell
    logic [whm_pkg::KEFF_W-1:0] kidx;
    logic [whm_pkg::HASH_W-1:0] coef;

    always_comb begin
      kidx = k_eff - whm_pkg::KEFF_W'(i + 1);
      coef = (whm_pkg::KEFF_W'(i) < k_eff) ?
             whm_pkg::WEIGHT[kidx[whm_pkg::WIN_IDX_W-1:0]] : '0;
    end

    if (i < whm_pkg::MAX_WINDOW - 1) begin : g_link
      whm_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .shift   (accept && stored),
        .sym_in  (chain[i]),
        .coef_in (coef),
        .sym_out (chain[i+1]),
        .prod    (prod[i])
      );
    end else begin : g_end
      whm_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .shift   (accept && stored),
        .sym_in  (chain[i]),
        .coef_in (coef),
        .sym_out (),
        .prod    (prod[i])
      );
    end
  end

  whm_sum_tree u_tree (
    .clk      (clk),
    .rst      (rst),
    .leaf     (prod),
    .meta_in  (meta_mul),
    .sum      (tree_sum),
    .meta_out (meta_tree)
  );

  whm_mod_reduce u_reduce (
    .clk      (clk),
    .rst      (rst),
    .sum_in   (tree_sum),
    .meta_in  (meta_tree),
    .hash     (red_hash),
    .meta_out (meta_red)
  );

  // first match per string, in request order
  assign hit = meta_red.valid && meta_red.elig && !found && (red_hash == target_hash);

  always_comb begin
    res_w.match       = hit;
    res_w.start_index = hit ? meta_red.start : '0;
    res_w.not_found   = meta_red.last && !found && !hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (meta_red.valid) begin
      found <= meta_red.last ? 1'b0 : (found || hit);
    end
  end

  whm_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (meta_red.valid),
    .wr_data    (res_w),
    .rd_en      (!res_stall),
    .head_valid (res_valid),
    .head       (res_data)
  );

endmodule

`default_nettype wire

// ----- rtl/core/whm_checker.sv -----
// Port-level checks for window_hash_matcher_top, bound to the top level.
// Depends on whm_pkg.
`default_nettype none

module whm_checker (
  input logic              clk,
  input logic              rst,
  input logic              sym_stall,
  input logic              res_valid,
  input logic              res_stall,
  input whm_pkg::res_req_t res_data
);

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid && !sym_stall)
    else $error("result or stall present after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  a_match_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.match && res_data.not_found))
    else $error("match and not_found together");

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.match |-> res_data.start_index == '0)
    else $error("start_index set without match");

endmodule

bind window_hash_matcher_top whm_checker u_whm_checker (.*);

`default_nettype wire
